/* hdl/bti_pkg.sv */
// ----------------------------------------------------------------------------
// bti_pkg
// Shared constants and types for the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;
   localparam int MaxPhasePoints    = 64;
   localparam int MaxVelocityPoints = 64;
   localparam int ValueWidth        = 24;
   localparam int BreakWidth        = 21;
   localparam int OutWidth          = 24;
   localparam int PointsWidth       = 7;
   localparam int IndexWidth        = 6;
   localparam logic signed [BreakWidth-1:0] PhaseTop = 21'sd411775;

   typedef enum logic [1:0] {
      OP_WR_PHASE = 2'd0,
      OP_WR_VEL   = 2'd1,
      OP_WR_GRID  = 2'd2,
      OP_EVAL     = 2'd3
   } op_type;

   localparam logic CSR_PHASE_POINTS = 1'b0;
   localparam logic CSR_VEL_POINTS   = 1'b1;
endpackage

/* hdl/bti_ram.sv */
// ----------------------------------------------------------------------------
// bti_ram
// Generic single-port write, single-port registered-read memory.
// ----------------------------------------------------------------------------
module bti_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/bti_divider.sv */
// ----------------------------------------------------------------------------
// bti_divider
// Restoring divider: floor(num * 65536 / den), 16 quotient bits, one a cycle.
// Used only with 0 < num < den, so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
module bti_divider #(
   parameter int W = 22
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [15:0]  quotient
);
   logic [W:0]   rem_ff, rem_in, trial;
   logic [W-1:0] den_ff;
   logic [15:0]  q_ff;
   logic [4:0]   cnt_ff;
   logic         busy_ff, done_ff;

   assign trial  = {rem_ff[W-1:0], 1'b0} - {1'b0, den_ff};
   assign rem_in = trial[W] ? {rem_ff[W-1:0], 1'b0} : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd16;
            rem_ff  <= {1'b0, num};
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= {q_ff[14:0], ~trial[W]};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

/* hdl/bilinear_table_interpolator_core.sv */
// Sequence: an evaluate scans the velocity breakpoints, then the phase breakpoints, then
//   reads the grid for each column used and blends it in phase (through the divider where
//   needed), then blends the columns in velocity. Throughput: one evaluate at a time; the
//   next transaction is accepted in the cycle after the result is taken. Writes can follow
//   back to back.
// Reset: synchronous, active high; point counts return to 2, memories keep contents.
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_core
// Bilinear interpolation over non-uniform phase/velocity breakpoint tables.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator_core #(
   parameter int MAX_PHASE_POINTS    = bti_pkg::MaxPhasePoints,
   parameter int MAX_VELOCITY_POINTS = bti_pkg::MaxVelocityPoints,
   parameter int VALUE_WIDTH         = bti_pkg::ValueWidth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic [bti_pkg::IndexWidth-1:0]   req_row_index,
   input  logic [bti_pkg::IndexWidth-1:0]   req_column_index,
   input  logic signed [20:0]               req_phase_in,
   input  logic signed [20:0]               req_velocity_in,
   input  logic signed [23:0]               req_write_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [bti_pkg::OutWidth-1:0] rsp_interpolated_value,
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [bti_pkg::PointsWidth-1:0]  csr_write_data
);
   import bti_pkg::*;

   localparam int PA = $clog2(MAX_PHASE_POINTS);
   localparam int VA = $clog2(MAX_VELOCITY_POINTS);
   localparam int GA = PA + VA;
   localparam int CW = $clog2(MAX_PHASE_POINTS + 1) > $clog2(MAX_VELOCITY_POINTS + 1) ?
                       $clog2(MAX_PHASE_POINTS + 1) : $clog2(MAX_VELOCITY_POINTS + 1);
   localparam int DW = VALUE_WIDTH + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_HI_RD, S_HI_WT, S_LO_RD, S_LO_WT, S_SR_RD, S_SR_WT, S_VSAVE,
      S_GA_RD, S_GA_WT, S_GB_RD, S_GB_WT, S_BL_CHK, S_BL_DIV, S_BL_MUL, S_BL_ADD,
      S_DONE, S_OUT
   } state_type;

   // ---------------- configuration ----------------
   logic [CW-1:0] np_ff, nv_ff;
   function automatic logic [CW-1:0] clamp_pts(input logic [PointsWidth-1:0] v,
                                                input int maxp);
      if (v < 2) return CW'(2);
      if (int'(v) > maxp) return CW'(maxp);
      return CW'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= CW'(2);
         nv_ff <= CW'(2);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_PHASE_POINTS)
            np_ff <= clamp_pts(csr_write_data, MAX_PHASE_POINTS);
         else
            nv_ff <= clamp_pts(csr_write_data, MAX_VELOCITY_POINTS);
      end
   end

   // ---------------- memories ----------------
   logic          pb_we, vb_we, g_we;
   logic [PA-1:0] pb_ra;
   logic [VA-1:0] vb_ra;
   logic [GA-1:0] g_ra;
   logic [BreakWidth-1:0]  pb_rd, vb_rd;
   logic [VALUE_WIDTH-1:0] g_rd, wr_val_ext;
   logic          req_fire;
   op_type        req_opc;

   assign req_fire   = req_valid && req_ready;
   assign req_opc    = op_type'(req_op);
   assign wr_val_ext = VALUE_WIDTH'(req_write_value);
   assign pb_we = req_fire && req_opc == OP_WR_PHASE && int'(req_row_index) < MAX_PHASE_POINTS;
   assign vb_we = req_fire && req_opc == OP_WR_VEL &&
                  int'(req_column_index) < MAX_VELOCITY_POINTS;
   assign g_we  = req_fire && req_opc == OP_WR_GRID &&
                  int'(req_row_index) < MAX_PHASE_POINTS &&
                  int'(req_column_index) < MAX_VELOCITY_POINTS;

   bti_ram #(.WIDTH(BreakWidth), .DEPTH(MAX_PHASE_POINTS)) u_pb (
      .clock(clock), .wr_en(pb_we), .wr_addr(PA'(req_row_index)),
      .wr_data(req_write_value[BreakWidth-1:0]), .rd_addr(pb_ra), .rd_data(pb_rd));
   bti_ram #(.WIDTH(BreakWidth), .DEPTH(MAX_VELOCITY_POINTS)) u_vb (
      .clock(clock), .wr_en(vb_we), .wr_addr(VA'(req_column_index)),
      .wr_data(req_write_value[BreakWidth-1:0]), .rd_addr(vb_ra), .rd_data(vb_rd));
   bti_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(1 << GA)) u_grid (
      .clock(clock), .wr_en(g_we),
      .wr_addr({PA'(req_row_index), VA'(req_column_index)}),
      .wr_data(wr_val_ext), .rd_addr(g_ra), .rd_data(g_rd));

   // ---------------- evaluation sequencer ----------------
   state_type state_ff;
   logic signed [BreakWidth-1:0]  p_ff, v_ff;
   logic signed [BreakWidth-1:0]  xa_ff, xb_ff, vxa_ff, vxb_ff;
   logic signed [VALUE_WIDTH-1:0] ya_ff, yb_ff, col0_ff, res_ff;
   logic [CW-1:0] k_ff, lo_ff, hi_ff, vlo_ff, vhi_ff, col_ff;
   logic          sel_vel_ff;
   logic          blend_ff, vblend_ff;
   logic          second_ff;
   logic          final_ff;
   logic [15:0]   f_ff;
   logic signed [DW+16:0] prod_ff;
   logic [OutWidth-1:0] rsp_ff;
   logic          rsp_valid_ff;

   logic [CW-1:0] n_sel, n_last;
   logic signed [BreakWidth-1:0] x_sel, brk;
   assign n_sel  = sel_vel_ff ? nv_ff : np_ff;
   assign n_last = n_sel - CW'(1);
   assign x_sel  = sel_vel_ff ? v_ff : p_ff;
   assign brk    = sel_vel_ff ? vb_rd : pb_rd;

   logic signed [BreakWidth-1:0] bl_x, bl_xa, bl_xb;
   assign bl_x  = final_ff ? v_ff : p_ff;
   assign bl_xa = final_ff ? vxa_ff : xa_ff;
   assign bl_xb = final_ff ? vxb_ff : xb_ff;

   logic          div_start, div_done;
   logic [15:0]   div_q;
   logic signed [BreakWidth:0] dnum, dden;
   assign dnum = {bl_x[BreakWidth-1], bl_x} - {bl_xa[BreakWidth-1], bl_xa};
   assign dden = {bl_xb[BreakWidth-1], bl_xb} - {bl_xa[BreakWidth-1], bl_xa};

   bti_divider #(.W(BreakWidth + 1)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(dnum), .den(dden),
      .done(div_done), .quotient(div_q));

   logic signed [DW-1:0] diff;
   assign diff = {yb_ff[VALUE_WIDTH-1], yb_ff} - {ya_ff[VALUE_WIDTH-1], ya_ff};

   logic signed [DW+16:0] prod_in;
   assign prod_in = diff * $signed({1'b0, f_ff});

   logic signed [VALUE_WIDTH-1:0] blend_out;
   assign blend_out = ya_ff + VALUE_WIDTH'(prod_ff >>> 16);

   logic pass_a, pass_b;
   assign pass_a = (dnum[BreakWidth] || dnum == '0 || dden[BreakWidth] || dden == '0);
   assign pass_b = !pass_a && (dnum >= dden);

   always_comb begin
      pb_ra = PA'(k_ff);
      vb_ra = VA'(k_ff);
      g_ra  = {PA'(lo_ff), VA'(col_ff)};
      case (state_ff)
         S_HI_RD: begin
            pb_ra = PA'(n_last);
            vb_ra = VA'(n_last);
         end
         S_LO_RD: begin
            pb_ra = '0;
            vb_ra = '0;
         end
         S_GB_RD: g_ra = {PA'(hi_ff), VA'(col_ff)};
         default: ;
      endcase
   end

   assign div_start = (state_ff == S_BL_CHK) && !pass_a && !pass_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_opc == OP_EVAL) begin
                  p_ff <= req_phase_in < 0 ? '0 :
                          (req_phase_in > PhaseTop ? PhaseTop : req_phase_in);
                  v_ff       <= req_velocity_in;
                  sel_vel_ff <= 1'b1;
                  second_ff  <= 1'b0;
                  final_ff   <= 1'b0;
                  state_ff   <= S_HI_RD;
               end
            end
            S_HI_RD: state_ff <= S_HI_WT;
            S_HI_WT: begin
               if (x_sel >= brk) begin
                  lo_ff    <= n_last;
                  hi_ff    <= n_last;
                  blend_ff <= 1'b0;
                  state_ff <= sel_vel_ff ? S_VSAVE : S_GA_RD;
               end else begin
                  state_ff <= S_LO_RD;
               end
            end
            S_LO_RD: state_ff <= S_LO_WT;
            S_LO_WT: begin
               if (x_sel <= brk) begin
                  lo_ff    <= '0;
                  hi_ff    <= '0;
                  blend_ff <= 1'b0;
                  state_ff <= sel_vel_ff ? S_VSAVE : S_GA_RD;
               end else begin
                  xa_ff    <= brk;
                  k_ff     <= CW'(1);
                  state_ff <= S_SR_RD;
               end
            end
            S_SR_RD: state_ff <= S_SR_WT;
            S_SR_WT: begin
               if (k_ff < n_last && x_sel >= brk) begin
                  xa_ff    <= brk;
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_SR_RD;
               end else begin
                  xb_ff    <= brk;
                  lo_ff    <= k_ff - CW'(1);
                  hi_ff    <= k_ff;
                  blend_ff <= 1'b1;
                  state_ff <= sel_vel_ff ? S_VSAVE : S_GA_RD;
               end
            end
            S_VSAVE: begin
               vlo_ff     <= lo_ff;
               vhi_ff     <= hi_ff;
               vxa_ff     <= xa_ff;
               vxb_ff     <= xb_ff;
               vblend_ff  <= blend_ff;
               col_ff     <= lo_ff;
               sel_vel_ff <= 1'b0;
               state_ff   <= S_HI_RD;
            end
            S_GA_RD: state_ff <= S_GA_WT;
            S_GA_WT: begin
               ya_ff <= g_rd;
               if (!blend_ff) begin
                  res_ff   <= g_rd;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_GB_RD;
               end
            end
            S_GB_RD: state_ff <= S_GB_WT;
            S_GB_WT: begin
               yb_ff    <= g_rd;
               state_ff <= S_BL_CHK;
            end
            S_BL_CHK: begin
               if (pass_a) begin
                  res_ff   <= ya_ff;
                  state_ff <= S_DONE;
               end else if (pass_b) begin
                  res_ff   <= yb_ff;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_BL_DIV;
               end
            end
            S_BL_DIV: begin
               if (div_done) begin
                  f_ff     <= div_q;
                  state_ff <= S_BL_MUL;
               end
            end
            S_BL_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_BL_ADD;
            end
            S_BL_ADD: begin
               res_ff   <= blend_out;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (final_ff || !vblend_ff) begin
                  rsp_ff       <= OutWidth'(res_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else if (!second_ff) begin
                  col0_ff   <= res_ff;
                  second_ff <= 1'b1;
                  col_ff    <= vhi_ff;
                  state_ff  <= S_GA_RD;
               end else begin
                  ya_ff    <= col0_ff;
                  yb_ff    <= res_ff;
                  final_ff <= 1'b1;
                  state_ff <= S_BL_CHK;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready              = (state_ff == S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_ff;

   a_no_ready_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opc == OP_EVAL |=> !req_ready) else $error("ready during evaluation");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interpolated_value))
      else $error("result dropped or changed");
endmodule
